// ----- design/audio_level_pitch_analyzer_defines.svh -----
// assertion macros for the audio level and pitch analyzer
`ifndef AUDIO_LEVEL_PITCH_ANALYZER_DEFINES_SVH
`define AUDIO_LEVEL_PITCH_ANALYZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ALPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ALPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ALPA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ALPA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/alpa_pkg.sv -----
`default_nettype none
package alpa_pkg;
    localparam int MAX_BUFFER = 2048;
    localparam int CNT_W = $clog2(MAX_BUFFER + 1);
    localparam int SUM_W = 30 + CNT_W;
    localparam int DIV_RAW = (SUM_W > 38) ? SUM_W : 38;
    localparam int DIV_W = DIV_RAW + (DIV_RAW % 2);
    localparam int DEN_W = 22;
    localparam int DREM_W = DEN_W + 1;
    localparam int ROOT_W = DIV_W / 2;
    localparam int SREM_W = ROOT_W + 2;
    localparam int DIV_STEPS = DIV_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int ITER_W = $clog2(DIV_STEPS);
    localparam int SILENCE_GATE = 99;
    localparam int SPEED_FLOOR = 205;
    localparam int SPEED_SPAN = 61235;
    localparam int AMP_SCALE = 5;

    localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
    localparam logic [2:0] REG_CROSS_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_MIN_LEVEL = 3'd2;
    localparam logic [2:0] REG_MAX_LEVEL = 3'd3;
    localparam logic [2:0] REG_MIN_PITCH = 3'd4;
    localparam logic [2:0] REG_MAX_PITCH = 3'd5;
    localparam logic [2:0] REG_LEVEL_SMOOTHING = 3'd6;
    localparam logic [2:0] REG_RATE_SMOOTHING = 3'd7;

    typedef struct packed {
        logic [17:0] sample_rate;
        logic [14:0] cross_threshold;
        logic [15:0] min_level;
        logic [15:0] max_level;
        logic [21:0] min_pitch;
        logic [21:0] max_pitch;
        logic [8:0]  level_smoothing;
        logic [8:0]  rate_smoothing;
    } cfg_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_SQUARE,
        CMD_ACCUM,
        CMD_LD_MEAN,
        CMD_DIV_STEP,
        CMD_LD_ROOT,
        CMD_SQRT_STEP,
        CMD_SET_LEVEL,
        CMD_SET_PITCH,
        CMD_LD_RAMP_LVL,
        CMD_LD_RAMP_PIT,
        CMD_GET_T_ROOT,
        CMD_GET_T,
        CMD_AMP_T,
        CMD_CUBE1,
        CMD_CUBE2,
        CMD_CUBE3,
        CMD_ZERO_TGT,
        CMD_LERP,
        CMD_EMIT_BUF,
        CMD_EMIT_FRM
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_MEAN_LD,
        ST_MEAN_DIV,
        ST_ROOT_LD,
        ST_ROOT,
        ST_LEVEL,
        ST_PITCH_DIV,
        ST_PITCH,
        ST_OUT_BUF,
        ST_GATE,
        ST_LVL_DIV,
        ST_LVL_T,
        ST_AMP_ROOT,
        ST_AMP_T,
        ST_PIT_LD,
        ST_PIT_DIV,
        ST_PIT_T,
        ST_CUBE1,
        ST_CUBE2,
        ST_CUBE3,
        ST_LERP,
        ST_OUT_FRM
    } state_t;

    typedef struct packed {
        logic buf_end;
        logic gate_open;
    } status_t;
endpackage
`default_nettype wire

// ----- design/audio_level_pitch_analyzer.sv -----
// sample request: latched, squared, then accumulated before the next is taken
// buffer end: shared restoring divider gives the mean, bit-pair square root the level,
// then the divider the pitch; the result waits while the output register is full
// frame tick: gate open maps targets by divider, root and cube steps; gate shut zeroes them
// results sit in an output register; a new request is taken while one waits
// rst_n is asynchronous and active low; it clears control state and loads register defaults
`default_nettype none
module audio_level_pitch_analyzer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic signed [15:0] sample,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    kind,
    output logic [15:0]             level_rms,
    output logic [21:0]             pitch_hz,
    output logic [14:0]             amplitude,
    output logic [15:0]             speed,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    alpa_pkg::cfg_t    cfg_reg;
    alpa_pkg::cmd_t    cmd;
    alpa_pkg::status_t status;
    logic [2:0]        reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_rate <= 18'd44100;
            cfg_reg.cross_threshold <= 15'd256;
            cfg_reg.min_level <= 16'd131;
            cfg_reg.max_level <= 16'd655;
            cfg_reg.min_pitch <= 22'd1280;
            cfg_reg.max_pitch <= 22'd4000;
            cfg_reg.level_smoothing <= 9'd51;
            cfg_reg.rate_smoothing <= 9'd90;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx)
                alpa_pkg::REG_SAMPLE_RATE:     cfg_reg.sample_rate <= pwdata[17:0];
                alpa_pkg::REG_CROSS_THRESHOLD: cfg_reg.cross_threshold <= pwdata[14:0];
                alpa_pkg::REG_MIN_LEVEL:       cfg_reg.min_level <= pwdata[15:0];
                alpa_pkg::REG_MAX_LEVEL:       cfg_reg.max_level <= pwdata[15:0];
                alpa_pkg::REG_MIN_PITCH:       cfg_reg.min_pitch <= pwdata[21:0];
                alpa_pkg::REG_MAX_PITCH:       cfg_reg.max_pitch <= pwdata[21:0];
                alpa_pkg::REG_LEVEL_SMOOTHING: cfg_reg.level_smoothing <= pwdata[8:0];
                alpa_pkg::REG_RATE_SMOOTHING:  cfg_reg.rate_smoothing <= pwdata[8:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            alpa_pkg::REG_SAMPLE_RATE:     prdata = 32'(cfg_reg.sample_rate);
            alpa_pkg::REG_CROSS_THRESHOLD: prdata = 32'(cfg_reg.cross_threshold);
            alpa_pkg::REG_MIN_LEVEL:       prdata = 32'(cfg_reg.min_level);
            alpa_pkg::REG_MAX_LEVEL:       prdata = 32'(cfg_reg.max_level);
            alpa_pkg::REG_MIN_PITCH:       prdata = 32'(cfg_reg.min_pitch);
            alpa_pkg::REG_MAX_PITCH:       prdata = 32'(cfg_reg.max_pitch);
            alpa_pkg::REG_LEVEL_SMOOTHING: prdata = 32'(cfg_reg.level_smoothing);
            alpa_pkg::REG_RATE_SMOOTHING:  prdata = 32'(cfg_reg.rate_smoothing);
            default:                       prdata = '0;
        endcase
    end

    alpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    alpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .sample    (sample),
        .last      (last),
        .status    (status),
        .kind      (kind),
        .level_rms (level_rms),
        .pitch_hz  (pitch_hz),
        .amplitude (amplitude),
        .speed     (speed)
    );
endmodule
`default_nettype wire

// ----- design/alpa_datapath.sv -----
`default_nettype none
module alpa_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire alpa_pkg::cmd_t      cmd,
    input  wire alpa_pkg::cfg_t      cfg,
    input  wire logic signed [15:0]  sample,
    input  wire logic                last,
    output alpa_pkg::status_t        status,
    output logic                     kind,
    output logic [15:0]              level_rms,
    output logic [21:0]              pitch_hz,
    output logic [14:0]              amplitude,
    output logic [15:0]              speed
);
    localparam int CW = alpa_pkg::CNT_W;
    localparam int DW = alpa_pkg::DIV_W;
    localparam int NW = alpa_pkg::DEN_W;
    localparam int RW = alpa_pkg::DREM_W;
    localparam int QW = alpa_pkg::ROOT_W;
    localparam int SW = alpa_pkg::SREM_W;

    logic [alpa_pkg::SUM_W-1:0] sum_sq_reg;
    logic [CW-1:0]              cnt_reg;
    logic [CW-1:0]              cross_reg;
    logic signed [15:0]         prev_reg;
    logic [15:0]                held_level_reg;
    logic [21:0]                held_pitch_reg;
    logic [14:0]                amp_reg;
    logic [15:0]                spd_reg;

    logic signed [15:0]         cur_reg;
    logic                       last_reg;
    logic [31:0]                sq_reg;
    logic [DW-1:0]              num_reg;
    logic [NW-1:0]              den_reg;
    logic [RW-1:0]              drem_reg;
    logic [SW-1:0]              srem_reg;
    logic [QW-1:0]              root_reg;
    logic                       t_hi_reg;
    logic                       t_lo_reg;
    logic [16:0]                t_reg;
    logic [17:0]                p_reg;
    logic [14:0]                amp_t_reg;
    logic [15:0]                spd_t_reg;

    logic signed [16:0] cur_x, prev_x, th_x;
    logic [16:0]        mag;
    logic               crossing;
    logic [RW:0]        div_try;
    logic               div_ge;
    logic [SW+1:0]      sq_try;
    logic [SW+1:0]      sq_trial;
    logic               sq_ge;
    logic [21:0]        rv, rlo, rhi;
    logic [16:0]        t_now;
    logic [CW+17:0]     pit_prod;
    logic [8:0]         fl_amp, fl_spd;
    logic               amp_up, spd_up;
    logic [14:0]        amp_d;
    logic [15:0]        spd_d;
    logic [23:0]        amp_m;
    logic [24:0]        spd_m;
    logic [19:0]        amp_prod;
    logic [33:0]        cube_a;
    logic [34:0]        cube_b;
    logic [33:0]        cube_c;

    always_comb
    begin
        cur_x = {cur_reg[15], cur_reg};
        prev_x = {prev_reg[15], prev_reg};
        th_x = {2'b00, cfg.cross_threshold};
        mag = cur_reg[15] ? 17'(-cur_x) : 17'(cur_x);
        crossing = (cnt_reg != '0)
                 && (((prev_x < -th_x) && (cur_x > th_x))
                 || ((prev_x > th_x) && (cur_x < -th_x)));
        div_try = {drem_reg, num_reg[DW-1]};
        div_ge = div_try >= (RW+1)'(den_reg);
        sq_try = {srem_reg, num_reg[DW-1:DW-2]};
        sq_trial = (SW+2)'({root_reg, 2'b01});
        sq_ge = sq_try >= sq_trial;
        if (cmd == alpa_pkg::CMD_LD_RAMP_LVL)
        begin
            rv = 22'(held_level_reg);
            rlo = 22'(cfg.min_level);
            rhi = 22'(cfg.max_level);
        end
        else
        begin
            rv = held_pitch_reg;
            rlo = cfg.min_pitch;
            rhi = cfg.max_pitch;
        end
        t_now = t_hi_reg ? 17'h10000 : (t_lo_reg ? 17'd0 : num_reg[16:0]);
        pit_prod = (CW+18)'(cross_reg) * (CW+18)'(cfg.sample_rate);
        fl_amp = (cfg.level_smoothing > 9'd256) ? 9'd256 : cfg.level_smoothing;
        fl_spd = (cfg.rate_smoothing > 9'd256) ? 9'd256 : cfg.rate_smoothing;
        amp_up = amp_t_reg >= amp_reg;
        spd_up = spd_t_reg >= spd_reg;
        amp_d = amp_up ? (amp_t_reg - amp_reg) : (amp_reg - amp_t_reg);
        spd_d = spd_up ? (spd_t_reg - spd_reg) : (spd_reg - spd_t_reg);
        amp_m = 24'(amp_d) * 24'(fl_amp);
        spd_m = 25'(spd_d) * 25'(fl_spd);
        amp_prod = 20'(root_reg[16:0]) * 20'(alpa_pkg::AMP_SCALE);
        cube_a = 34'(t_reg) * 34'(t_reg);
        cube_b = 35'(p_reg) * 35'(t_reg);
        cube_c = 34'(p_reg) * 34'(alpa_pkg::SPEED_SPAN);
        status.buf_end = last_reg
            || (cnt_reg == CW'(alpa_pkg::MAX_BUFFER - 1));
        status.gate_open = held_level_reg >= 16'(alpa_pkg::SILENCE_GATE);
    end

    // per-buffer accumulators and held results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_sq_reg <= '0;
            cnt_reg <= '0;
            cross_reg <= '0;
            prev_reg <= '0;
            held_level_reg <= '0;
            held_pitch_reg <= '0;
            amp_reg <= '0;
            spd_reg <= '0;
        end
        else
        begin
            case (cmd)
                alpa_pkg::CMD_ACCUM:
                begin
                    sum_sq_reg <= sum_sq_reg + alpa_pkg::SUM_W'(sq_reg);
                    if (crossing)
                        cross_reg <= cross_reg + 1'b1;
                    prev_reg <= cur_reg;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                alpa_pkg::CMD_SET_LEVEL:
                    held_level_reg <= root_reg[15:0];
                alpa_pkg::CMD_SET_PITCH:
                begin
                    held_pitch_reg <= (cross_reg >= CW'(2)) ? num_reg[21:0] : 22'd0;
                    sum_sq_reg <= '0;
                    cnt_reg <= '0;
                    cross_reg <= '0;
                    prev_reg <= '0;
                end
                alpa_pkg::CMD_LERP:
                begin
                    amp_reg <= amp_up ? (amp_reg + amp_m[22:8]) : (amp_reg - amp_m[22:8]);
                    spd_reg <= spd_up ? (spd_reg + spd_m[23:8]) : (spd_reg - spd_m[23:8]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // shared divider, root and mapping work registers, sample latch and output registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            alpa_pkg::CMD_LATCH:
            begin
                cur_reg <= sample;
                last_reg <= last;
            end
            alpa_pkg::CMD_SQUARE:
                sq_reg <= 32'(mag) * 32'(mag);
            alpa_pkg::CMD_LD_MEAN:
            begin
                num_reg <= DW'(sum_sq_reg);
                den_reg <= NW'(cnt_reg);
                drem_reg <= '0;
            end
            alpa_pkg::CMD_DIV_STEP:
            begin
                drem_reg <= div_ge ? RW'(div_try - (RW+1)'(den_reg)) : RW'(div_try);
                num_reg <= {num_reg[DW-2:0], div_ge};
            end
            alpa_pkg::CMD_LD_ROOT:
            begin
                srem_reg <= '0;
                root_reg <= '0;
            end
            alpa_pkg::CMD_SQRT_STEP:
            begin
                srem_reg <= sq_ge ? SW'(sq_try - sq_trial) : SW'(sq_try);
                root_reg <= {root_reg[QW-2:0], sq_ge};
                num_reg <= {num_reg[DW-3:0], 2'b00};
            end
            alpa_pkg::CMD_SET_LEVEL:
            begin
                num_reg <= DW'({pit_prod, 3'b000});
                den_reg <= NW'(cnt_reg);
                drem_reg <= '0;
            end
            alpa_pkg::CMD_LD_RAMP_LVL, alpa_pkg::CMD_LD_RAMP_PIT:
            begin
                t_hi_reg <= rv >= rhi;
                t_lo_reg <= rv <= rlo;
                num_reg <= DW'({22'(rv - rlo), 16'h0000});
                den_reg <= NW'(rhi - rlo);
                drem_reg <= '0;
            end
            alpa_pkg::CMD_GET_T_ROOT:
            begin
                t_reg <= t_now;
                num_reg <= DW'({t_now, 16'h0000});
                srem_reg <= '0;
                root_reg <= '0;
            end
            alpa_pkg::CMD_GET_T:
                t_reg <= t_now;
            alpa_pkg::CMD_AMP_T:
                amp_t_reg <= amp_prod[18:4];
            alpa_pkg::CMD_CUBE1:
                p_reg <= cube_a[33:16];
            alpa_pkg::CMD_CUBE2:
                p_reg <= cube_b[33:16];
            alpa_pkg::CMD_CUBE3:
                spd_t_reg <= 16'(alpa_pkg::SPEED_FLOOR) + cube_c[31:16];
            alpa_pkg::CMD_ZERO_TGT:
            begin
                amp_t_reg <= '0;
                spd_t_reg <= '0;
            end
            alpa_pkg::CMD_EMIT_BUF, alpa_pkg::CMD_EMIT_FRM:
            begin
                kind <= (cmd == alpa_pkg::CMD_EMIT_FRM);
                level_rms <= held_level_reg;
                pitch_hz <= held_pitch_reg;
                amplitude <= amp_reg;
                speed <= spd_reg;
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- design/alpa_ctrl.sv -----
`default_nettype none
`include "audio_level_pitch_analyzer_defines.svh"
module alpa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire alpa_pkg::status_t  status,
    output alpa_pkg::cmd_t          cmd
);
    alpa_pkg::state_t state_reg, state_next;
    logic [alpa_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic out_valid_reg, out_valid_next;
    logic div_last, root_last, slot_free, emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alpa_pkg::ST_IDLE;
            iter_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        div_last = iter_reg == alpa_pkg::ITER_W'(alpa_pkg::DIV_STEPS - 1);
        root_last = iter_reg == alpa_pkg::ITER_W'(alpa_pkg::ROOT_STEPS - 1);
        slot_free = !out_valid_reg || out_ready;
        state_next = state_reg;
        cmd = alpa_pkg::CMD_NONE;
        in_ready = 1'b0;
        iter_next = '0;
        case (state_reg)
            alpa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = alpa_pkg::CMD_LATCH;
                    state_next = action ? alpa_pkg::ST_GATE : alpa_pkg::ST_SQUARE;
                end
            end
            alpa_pkg::ST_SQUARE:
            begin
                cmd = alpa_pkg::CMD_SQUARE;
                state_next = alpa_pkg::ST_ACCUM;
            end
            alpa_pkg::ST_ACCUM:
            begin
                cmd = alpa_pkg::CMD_ACCUM;
                state_next = status.buf_end ? alpa_pkg::ST_MEAN_LD : alpa_pkg::ST_IDLE;
            end
            alpa_pkg::ST_MEAN_LD:
            begin
                cmd = alpa_pkg::CMD_LD_MEAN;
                state_next = alpa_pkg::ST_MEAN_DIV;
            end
            alpa_pkg::ST_MEAN_DIV:
            begin
                cmd = alpa_pkg::CMD_DIV_STEP;
                iter_next = iter_reg + 1'b1;
                if (div_last)
                    state_next = alpa_pkg::ST_ROOT_LD;
            end
            alpa_pkg::ST_ROOT_LD:
            begin
                cmd = alpa_pkg::CMD_LD_ROOT;
                state_next = alpa_pkg::ST_ROOT;
            end
            alpa_pkg::ST_ROOT:
            begin
                cmd = alpa_pkg::CMD_SQRT_STEP;
                iter_next = iter_reg + 1'b1;
                if (root_last)
                    state_next = alpa_pkg::ST_LEVEL;
            end
            alpa_pkg::ST_LEVEL:
            begin
                cmd = alpa_pkg::CMD_SET_LEVEL;
                state_next = alpa_pkg::ST_PITCH_DIV;
            end
            alpa_pkg::ST_PITCH_DIV:
            begin
                cmd = alpa_pkg::CMD_DIV_STEP;
                iter_next = iter_reg + 1'b1;
                if (div_last)
                    state_next = alpa_pkg::ST_PITCH;
            end
            alpa_pkg::ST_PITCH:
            begin
                cmd = alpa_pkg::CMD_SET_PITCH;
                state_next = alpa_pkg::ST_OUT_BUF;
            end
            alpa_pkg::ST_OUT_BUF:
            begin
                if (slot_free)
                begin
                    cmd = alpa_pkg::CMD_EMIT_BUF;
                    state_next = alpa_pkg::ST_IDLE;
                end
            end
            alpa_pkg::ST_GATE:
            begin
                if (status.gate_open)
                begin
                    cmd = alpa_pkg::CMD_LD_RAMP_LVL;
                    state_next = alpa_pkg::ST_LVL_DIV;
                end
                else
                begin
                    cmd = alpa_pkg::CMD_ZERO_TGT;
                    state_next = alpa_pkg::ST_LERP;
                end
            end
            alpa_pkg::ST_LVL_DIV:
            begin
                cmd = alpa_pkg::CMD_DIV_STEP;
                iter_next = iter_reg + 1'b1;
                if (div_last)
                    state_next = alpa_pkg::ST_LVL_T;
            end
            alpa_pkg::ST_LVL_T:
            begin
                cmd = alpa_pkg::CMD_GET_T_ROOT;
                state_next = alpa_pkg::ST_AMP_ROOT;
            end
            alpa_pkg::ST_AMP_ROOT:
            begin
                cmd = alpa_pkg::CMD_SQRT_STEP;
                iter_next = iter_reg + 1'b1;
                if (root_last)
                    state_next = alpa_pkg::ST_AMP_T;
            end
            alpa_pkg::ST_AMP_T:
            begin
                cmd = alpa_pkg::CMD_AMP_T;
                state_next = alpa_pkg::ST_PIT_LD;
            end
            alpa_pkg::ST_PIT_LD:
            begin
                cmd = alpa_pkg::CMD_LD_RAMP_PIT;
                state_next = alpa_pkg::ST_PIT_DIV;
            end
            alpa_pkg::ST_PIT_DIV:
            begin
                cmd = alpa_pkg::CMD_DIV_STEP;
                iter_next = iter_reg + 1'b1;
                if (div_last)
                    state_next = alpa_pkg::ST_PIT_T;
            end
            alpa_pkg::ST_PIT_T:
            begin
                cmd = alpa_pkg::CMD_GET_T;
                state_next = alpa_pkg::ST_CUBE1;
            end
            alpa_pkg::ST_CUBE1:
            begin
                cmd = alpa_pkg::CMD_CUBE1;
                state_next = alpa_pkg::ST_CUBE2;
            end
            alpa_pkg::ST_CUBE2:
            begin
                cmd = alpa_pkg::CMD_CUBE2;
                state_next = alpa_pkg::ST_CUBE3;
            end
            alpa_pkg::ST_CUBE3:
            begin
                cmd = alpa_pkg::CMD_CUBE3;
                state_next = alpa_pkg::ST_LERP;
            end
            alpa_pkg::ST_LERP:
            begin
                cmd = alpa_pkg::CMD_LERP;
                state_next = alpa_pkg::ST_OUT_FRM;
            end
            alpa_pkg::ST_OUT_FRM:
            begin
                if (slot_free)
                begin
                    cmd = alpa_pkg::CMD_EMIT_FRM;
                    state_next = alpa_pkg::ST_IDLE;
                end
            end
            default:
                state_next = alpa_pkg::ST_IDLE;
        endcase
        emit = (cmd == alpa_pkg::CMD_EMIT_BUF) || (cmd == alpa_pkg::CMD_EMIT_FRM);
        out_valid_next = emit || (out_valid_reg && !out_ready);
        out_valid = out_valid_reg;
    end

    `ALPA_ASSERT_NXT(a_sample_to_square, clk, rst_n, in_valid && in_ready && !action, state_reg == alpa_pkg::ST_SQUARE)
    `ALPA_ASSERT_IMP(a_emit_slot_free, clk, rst_n, emit, !out_valid_reg || out_ready)
    `ALPA_ASSERT_IMP(a_iter_bound, clk, rst_n, state_reg == alpa_pkg::ST_ROOT || state_reg == alpa_pkg::ST_AMP_ROOT, iter_reg < alpa_pkg::ITER_W'(alpa_pkg::ROOT_STEPS))
    `ALPA_ASSERT_NXT(a_result_held, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg && !in_ready || out_valid_reg)
endmodule
`default_nettype wire
